// ----- rtl/ir_command_esc_speed_control_unit_macros.svh -----
`ifndef IR_COMMAND_ESC_SPEED_CONTROL_UNIT_MACROS_SVH
`define IR_COMMAND_ESC_SPEED_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i and masked during reset.
`define IRCESC_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and masked during reset.
`define IRCESC_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ircesc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ircesc_pkg;

  localparam int unsigned PulseWidth = 12;
  localparam int unsigned StepWidth  = 8;
  localparam int unsigned CodeWidth  = 32;
  localparam int unsigned NumMotors  = 4;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [PulseWidth-1:0] ResetSpeed      = 12'd1300;
  localparam logic [PulseWidth-1:0] ResetOffPulse   = 12'd1300;
  localparam logic [PulseWidth-1:0] ResetFullPulse  = 12'd2000;
  localparam logic [PulseWidth-1:0] ResetClampLow   = 12'd1300;
  localparam logic [PulseWidth-1:0] ResetClampHigh  = 12'd2000;
  localparam logic [StepWidth-1:0]  ResetCoarseStep = 8'd25;
  localparam logic [StepWidth-1:0]  ResetFineStep   = 8'd1;

  localparam logic [CodeWidth-1:0] CodeRepeat = 32'hFFFF_FFFF;
  localparam logic [CodeWidth-1:0] CodeOff    = 32'h00FF_A25D;
  localparam logic [CodeWidth-1:0] CodeFull   = 32'hE13E_0DF2;
  localparam logic [CodeWidth-1:0] CodeUp     = 32'hE13E_C53A;
  localparam logic [CodeWidth-1:0] CodeDown   = 32'hE13E_25DA;
  localparam logic [CodeWidth-1:0] CodeTrimA  = 32'hE13E_5DA2;
  localparam logic [CodeWidth-1:0] CodeTrimB  = 32'hE13E_C43B;
  localparam logic [CodeWidth-1:0] CodeTrimC  = 32'hE13E_44BB;
  localparam logic [CodeWidth-1:0] CodeTrimD  = 32'hE13E_DD22;
  localparam logic [CodeWidth-1:0] CodeToggle = 32'hE13E_05FA;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_OFF_PULSE   = 3'd0,
    CFG_FULL_PULSE  = 3'd1,
    CFG_CLAMP_LOW   = 3'd2,
    CFG_CLAMP_HIGH  = 3'd3,
    CFG_COARSE_STEP = 3'd4,
    CFG_FINE_STEP   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_OFF,
    CMD_FULL,
    CMD_UP,
    CMD_DOWN,
    CMD_TRIM_A,
    CMD_TRIM_B,
    CMD_TRIM_C,
    CMD_TRIM_D,
    CMD_TOGGLE,
    CMD_OTHER
  } cmd_e;

  typedef struct packed {
    logic [CodeWidth-1:0] ir_code;
  } cmd_t;

  typedef struct packed {
    logic                  esc_write;
    logic [PulseWidth-1:0] pulse_one;
    logic [PulseWidth-1:0] pulse_two;
    logic [PulseWidth-1:0] pulse_three;
    logic [PulseWidth-1:0] pulse_four;
    logic                  led_on;
  } res_t;

  function automatic cmd_e decode_cmd(input logic [CodeWidth-1:0] code);
    cmd_e cmd;
    case (code)
      CodeOff:    cmd = CMD_OFF;
      CodeFull:   cmd = CMD_FULL;
      CodeUp:     cmd = CMD_UP;
      CodeDown:   cmd = CMD_DOWN;
      CodeTrimA:  cmd = CMD_TRIM_A;
      CodeTrimB:  cmd = CMD_TRIM_B;
      CodeTrimC:  cmd = CMD_TRIM_C;
      CodeTrimD:  cmd = CMD_TRIM_D;
      CodeToggle: cmd = CMD_TOGGLE;
      default:    cmd = CMD_OTHER;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ircesc_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ircesc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/ir_command_esc_speed_control_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                   Handshake
// cmd_if    in   ir_code[31:0]                             valid/ready
// res_if    out  esc_write, pulse_one..four[11:0], led_on  valid/ready
// cfg       in   cfg_idx_i[2:0], cfg_data_i[11:0]          cfg_we_i, no stall
//
// One item per cycle sustained while res_if.ready stays high.
// The code lands in an input register, then one pass of decode, add/saturate
// and clamp updates the motor state and fills the result register.
// The input register keeps taking items while a result waits; it stalls only
// when both registers are full and res_if.ready is low.
// Reset (rst_ni low, asynchronous) restores speeds, mode, codes and registers.

`include "ir_command_esc_speed_control_unit_macros.svh"

module ir_command_esc_speed_control_unit
  import ircesc_pkg::*;
#(
  parameter int unsigned SPEED_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [PulseWidth-1:0]  cfg_data_i,
  ircesc_stream_if.sink               cmd_if,
  ircesc_stream_if.source             res_if
);

  localparam int unsigned SW = SPEED_WIDTH;

  typedef logic signed [SW-1:0] speed_t;
  typedef logic signed [SW:0]   wide_t;

  // configuration registers
  logic [PulseWidth-1:0] off_pulse_q, full_pulse_q, clamp_low_q, clamp_high_q;
  logic [StepWidth-1:0]  coarse_step_q, fine_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_pulse_q   <= ResetOffPulse;
      full_pulse_q  <= ResetFullPulse;
      clamp_low_q   <= ResetClampLow;
      clamp_high_q  <= ResetClampHigh;
      coarse_step_q <= ResetCoarseStep;
      fine_step_q   <= ResetFineStep;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OFF_PULSE:   off_pulse_q   <= cfg_data_i;
        CFG_FULL_PULSE:  full_pulse_q  <= cfg_data_i;
        CFG_CLAMP_LOW:   clamp_low_q   <= cfg_data_i;
        CFG_CLAMP_HIGH:  clamp_high_q  <= cfg_data_i;
        CFG_COARSE_STEP: coarse_step_q <= cfg_data_i[StepWidth-1:0];
        CFG_FINE_STEP:   fine_step_q   <= cfg_data_i[StepWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic                 cmd_valid_q;
  logic [CodeWidth-1:0] cmd_code_q;
  logic                 res_valid_q;
  res_t                 res_q, res_d;
  logic                 advance;
  logic                 cmd_accept;

  assign advance      = cmd_valid_q && (!res_valid_q || res_if.ready);
  assign cmd_if.ready = !cmd_valid_q || advance;
  assign cmd_accept   = cmd_if.valid && cmd_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd_accept) begin
      cmd_valid_q <= 1'b1;
    end else if (advance) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      cmd_code_q <= cmd_if.payload.ir_code;
    end
  end

  // control state
  speed_t               speed_q [NumMotors];
  speed_t               speed_d [NumMotors];
  logic                 single_q, single_d;
  logic [CodeWidth-1:0] last_code_q, last_code_d;
  logic                 write_q, write_d;
  logic                 led_q, led_d;

  function automatic speed_t sat_speed(input wide_t v);
    speed_t r;
    if (v[SW] != v[SW-1]) begin
      r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  function automatic wide_t widen_pulse(input logic [PulseWidth-1:0] p);
    return {{(SW+1-PulseWidth){1'b0}}, p};
  endfunction

  function automatic logic [PulseWidth-1:0] clamp_pulse(
    input speed_t                v,
    input logic [PulseWidth-1:0] lo,
    input logic [PulseWidth-1:0] hi
  );
    wide_t                 vw;
    logic [PulseWidth-1:0] r;
    vw = {v[SW-1], v};
    if (vw < $signed(widen_pulse(lo))) begin
      r = lo;
    end else if (vw > $signed(widen_pulse(hi))) begin
      r = hi;
    end else begin
      r = v[PulseWidth-1:0];
    end
    return r;
  endfunction

  logic [CodeWidth-1:0] code;
  cmd_e                 cmd;
  logic                 load_all;
  logic [PulseWidth-1:0] load_val;
  logic [NumMotors-1:0] adj_mask;
  logic signed [StepWidth:0] delta9;
  wide_t                delta;
  wide_t                load_ext;

  always_comb begin
    // substitute the repeat code with the remembered one
    code = (cmd_code_q == CodeRepeat) ? last_code_q : cmd_code_q;
    cmd  = decode_cmd(code);

    single_d    = single_q;
    last_code_d = last_code_q;
    write_d     = write_q;
    led_d       = led_q;
    load_all    = 1'b0;
    load_val    = off_pulse_q;
    adj_mask    = '0;
    delta9      = -$signed({1'b0, fine_step_q});

    case (cmd)
      CMD_OFF: begin
        write_d  = 1'b1;
        load_all = 1'b1;
        load_val = off_pulse_q;
      end
      CMD_FULL: begin
        write_d  = 1'b1;
        load_all = 1'b1;
        load_val = full_pulse_q;
      end
      CMD_UP: begin
        write_d  = 1'b1;
        adj_mask = '1;
        delta9   = $signed({1'b0, coarse_step_q});
      end
      CMD_DOWN: begin
        write_d  = 1'b1;
        adj_mask = '1;
        delta9   = -$signed({1'b0, coarse_step_q});
      end
      CMD_TRIM_A: begin
        write_d     = 1'b1;
        last_code_d = code;
        adj_mask    = single_q ? 4'b0010 : 4'b0110;
      end
      CMD_TRIM_B: begin
        write_d     = 1'b1;
        last_code_d = code;
        adj_mask    = single_q ? 4'b0001 : 4'b1001;
      end
      CMD_TRIM_C: begin
        write_d     = 1'b1;
        last_code_d = code;
        adj_mask    = single_q ? 4'b0100 : 4'b0101;
      end
      CMD_TRIM_D: begin
        write_d     = 1'b1;
        last_code_d = code;
        adj_mask    = single_q ? 4'b1000 : 4'b1010;
      end
      CMD_TOGGLE: begin
        led_d    = single_q;
        single_d = !single_q;
      end
      default: begin
        write_d     = 1'b0;
        last_code_d = code;
      end
    endcase

    delta    = {{(SW-StepWidth){delta9[StepWidth]}}, delta9};
    load_ext = widen_pulse(load_val);

    for (int i = 0; i < NumMotors; i++) begin
      if (load_all) begin
        speed_d[i] = sat_speed(load_ext);
      end else if (adj_mask[i]) begin
        speed_d[i] = sat_speed({speed_q[i][SW-1], speed_q[i]} + delta);
      end else begin
        speed_d[i] = speed_q[i];
      end
    end

    res_d.esc_write   = write_d;
    res_d.pulse_one   = clamp_pulse(speed_d[0], clamp_low_q, clamp_high_q);
    res_d.pulse_two   = clamp_pulse(speed_d[1], clamp_low_q, clamp_high_q);
    res_d.pulse_three = clamp_pulse(speed_d[2], clamp_low_q, clamp_high_q);
    res_d.pulse_four  = clamp_pulse(speed_d[3], clamp_low_q, clamp_high_q);
    res_d.led_on      = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        speed_q[i] <= speed_t'(ResetSpeed);
      end
      single_q    <= 1'b0;
      last_code_q <= '0;
      write_q     <= 1'b0;
      led_q       <= 1'b0;
    end else if (advance) begin
      speed_q     <= speed_d;
      single_q    <= single_d;
      last_code_q <= last_code_d;
      write_q     <= write_d;
      led_q       <= led_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_if.valid   = res_valid_q;
  assign res_if.payload = res_q;

  `IRCESC_ASSERT_NOW(a_stall_when_full, cmd_valid_q && res_valid_q && !res_if.ready, !cmd_if.ready, "input taken while both stages are full")
  `IRCESC_ASSERT_NEXT(a_toggle_led, advance && cmd == CMD_TOGGLE, res_if.payload.led_on == $past(single_q) && single_q != $past(single_q), "mode toggle did not update indicator")
  `IRCESC_ASSERT_NEXT(a_unknown_clears_write, advance && cmd == CMD_OTHER, !res_if.payload.esc_write && last_code_q == $past(code), "unknown code must clear write and store code")
  `IRCESC_ASSERT_NOW(a_repeat_never_stored, 1'b1, last_code_q != CodeRepeat, "repeat code stored as last code")

endmodule

`default_nettype wire
